>>> rtl/base64url_stream_decoder_core_defines.svh
// assertion macros shared by the decoder rtl
`ifndef BASE64URL_STREAM_DECODER_CORE_DEFINES_SVH
`define BASE64URL_STREAM_DECODER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define B64D_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("b64d assertion failed");

// next-cycle implication, checked out of reset
`define B64D_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("b64d assertion failed");

`endif

>>> rtl/b64d_pkg.sv
// shared types, status codes and symbol table for the base64url decoder
package b64d_pkg;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_CHAR = 3'd1;
    localparam logic [2:0] ST_DANGLING = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_TAIL     = 3'd4;

    localparam logic [7:0] NO_SYMBOL = 8'hFF;
    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        finished;
        logic [2:0]  status;
        logic [15:0] decoded_length;
    } out_word_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] partial_byte;
        logic       draining;
    } msg_state_t;

    function automatic logic [7:0] symbol_value(input logic [7:0] c);
        logic [7:0] v;
        v = NO_SYMBOL;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30 + 8'd52;
        end else if (c == 8'h2D) begin
            v = 8'd62;
        end else if (c == 8'h5F) begin
            v = 8'd63;
        end
        return v;
    endfunction

endpackage

>>> rtl/b64d_step.sv
// per-character decode: next message state and the result word
module b64d_step
    import b64d_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  in_word_t               in_word,
    input  msg_state_t             cur_state,
    input  logic [COUNT_WIDTH-1:0] cur_count,
    input  logic [15:0]            capacity,
    output msg_state_t             nxt_state,
    output logic [COUNT_WIDTH-1:0] nxt_count,
    output logic                   emit,
    output out_word_t              result
);

    localparam int EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [7:0]             sym;
    logic [5:0]             x;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [EXT_W-1:0]       cnt_ext;
    logic [EXT_W-1:0]       inc_ext;
    logic [EXT_W-1:0]       cap_ext;
    logic [7:0]             dec_byte;
    logic [7:0]             tail;
    logic                   mid_group;

    assign sym     = symbol_value(in_word.text_char);
    assign x       = sym[5:0];
    assign cnt_inc = cur_count + COUNT_WIDTH'(1);
    assign cnt_ext = EXT_W'(cur_count);
    assign inc_ext = EXT_W'(cnt_inc);
    assign cap_ext = EXT_W'(capacity);

    always_comb begin
        nxt_state = cur_state;
        nxt_count = cur_count;
        emit      = 1'b0;
        result    = '0;
        result.decoded_length = cnt_ext[15:0];
        dec_byte  = 8'h00;
        tail      = 8'h00;
        mid_group = 1'b0;

        if (cur_state.draining) begin
            if (in_word.end_of_text) begin
                nxt_state = '0;
                nxt_count = '0;
            end
        end else if (in_word.end_of_text) begin
            emit            = 1'b1;
            result.finished = 1'b1;
            result.status   = (cur_state.phase == 2'd1) ? ST_DANGLING : ST_OK;
            nxt_state       = '0;
            nxt_count       = '0;
        end else if (sym == NO_SYMBOL) begin
            emit               = 1'b1;
            result.finished    = 1'b1;
            result.status      = ST_BAD_CHAR;
            nxt_state.draining = 1'b1;
        end else if (cnt_ext == cap_ext) begin
            emit               = 1'b1;
            result.finished    = 1'b1;
            result.status      = ST_FULL;
            nxt_state.draining = 1'b1;
        end else begin
            case (cur_state.phase)
                2'd0: begin
                    nxt_state.partial_byte = {x, 2'b00};
                    nxt_state.phase        = 2'd1;
                end
                2'd1: begin
                    dec_byte  = cur_state.partial_byte | {6'b0, x[5:4]};
                    tail      = {x[3:0], 4'b0};
                    mid_group = 1'b1;
                end
                2'd2: begin
                    dec_byte  = cur_state.partial_byte | {4'b0, x[5:2]};
                    tail      = {x[1:0], 6'b0};
                    mid_group = 1'b1;
                end
                default: begin
                    dec_byte               = cur_state.partial_byte | {2'b0, x};
                    nxt_count              = cnt_inc;
                    nxt_state.partial_byte = 8'h00;
                    nxt_state.phase        = 2'd0;
                    emit                   = 1'b1;
                    result.data_byte       = dec_byte;
                    result.byte_valid      = 1'b1;
                    result.decoded_length  = inc_ext[15:0];
                end
            endcase

            if (mid_group) begin
                nxt_count             = cnt_inc;
                emit                  = 1'b1;
                result.data_byte      = dec_byte;
                result.byte_valid     = 1'b1;
                result.decoded_length = inc_ext[15:0];
                if (inc_ext == cap_ext) begin
                    nxt_state.draining = 1'b1;
                    result.finished    = 1'b1;
                    result.status      = (tail == 8'h00) ? ST_OK : ST_TAIL;
                end else begin
                    nxt_state.partial_byte = tail;
                    nxt_state.phase        = cur_state.phase + 2'd1;
                end
            end
        end
    end

endmodule

>>> rtl/base64url_stream_decoder_core.sv
// base64url stream decoder top level: state, config and output registers
//
// Input channel s_valid/s_ready/s_data carries one word per character:
// an ASCII character, or the end-of-text flag that closes a message.
// Output channel m_valid/m_ready/m_data carries zero or one word per
// input word: a decoded byte, a final status with the byte count, or both.
// Each input word is decoded in the cycle it is accepted and its result
// appears on m_data in the next cycle; one word per cycle while m_ready holds.
// The output register is the only buffer; s_ready is high whenever it is
// empty or is being emptied in the same cycle, so a stalled receiver
// stops the input after a single pending result.
// cfg_wr_en/cfg_wr_data write the output capacity; write it only while
// no message result is outstanding.
// After a message ends on an error or a full output, characters are
// dropped without result until the end-of-text word.
// Synchronous active-low reset sets capacity to 65535 and clears the
// message state and the output valid flag.
`include "base64url_stream_decoder_core_defines.svh"

module base64url_stream_decoder_core
    import b64d_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data
);

    msg_state_t             state_reg;
    msg_state_t             state_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [15:0]            capacity_reg;
    logic                   m_valid_reg;
    out_word_t              m_data_reg;
    logic                   emit;
    out_word_t              result;
    logic                   accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    b64d_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .in_word   (s_data),
        .cur_state (state_reg),
        .cur_count (count_reg),
        .capacity  (capacity_reg),
        .nxt_state (state_next),
        .nxt_count (count_next),
        .emit      (emit),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= '0;
            count_reg    <= '0;
            capacity_reg <= CAPACITY_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            if (accept) begin
                state_reg   <= state_next;
                count_reg   <= count_next;
                m_valid_reg <= emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_data_reg <= result;
        end
    end

    // status is only reported on the closing word
    `B64D_ASSERT_NOW(a_status_only_when_finished, aclk, aresetn,
        m_valid && !m_data.finished, m_data.status == ST_OK)
    // no byte means a zero data field
    `B64D_ASSERT_NOW(a_byte_zero_when_invalid, aclk, aresetn,
        m_valid && !m_data.byte_valid, m_data.data_byte == 8'h00)
    // end of text always restarts the message
    `B64D_ASSERT_NEXT(a_eot_clears_state, aclk, aresetn,
        accept && s_data.end_of_text,
        state_reg == '0 && count_reg == '0)
    // an accepted word with a result is presented next cycle
    `B64D_ASSERT_NEXT(a_result_presented, aclk, aresetn,
        accept && emit, m_valid_reg)

endmodule

>>> tb/b64d_checker.sv
// checker for the base64url decoder: tracks both channels, predicts and compares words
`timescale 1ns / 100ps

module b64d_checker
    import b64d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_word_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_word_t   m_data,
    output int          mismatches,
    output int          outstanding
);

    logic [15:0] capacity;
    logic [1:0]  group_pos;
    logic [7:0]  carry_bits;
    logic [15:0] byte_total;
    logic        dropping;
    out_word_t   expected_words[$];

    function automatic logic [7:0] sextet_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c - "A";
        end else if (c >= "a" && c <= "z") begin
            return c - "a" + 8'd26;
        end else if (c >= "0" && c <= "9") begin
            return c - "0" + 8'd52;
        end else if (c == "-") begin
            return 8'd62;
        end else if (c == "_") begin
            return 8'd63;
        end
        return NO_SYMBOL;
    endfunction

    task automatic restart_message();
        group_pos  = 2'd0;
        carry_bits = 8'd0;
        byte_total = 16'd0;
        dropping   = 1'b0;
    endtask

    task automatic predict_word(input in_word_t w);
        logic [7:0] x;
        logic [7:0] full_byte;
        logic [7:0] next_bits;
        out_word_t  r;
        r = '0;
        next_bits = 8'd0;
        full_byte = 8'd0;
        if (dropping) begin
            if (w.end_of_text) begin
                restart_message();
            end
            return;
        end
        if (w.end_of_text) begin
            r.finished = 1'b1;
            r.status = (group_pos == 2'd1) ? ST_DANGLING : ST_OK;
            r.decoded_length = byte_total;
            expected_words.push_back(r);
            restart_message();
            return;
        end
        x = sextet_of(w.text_char);
        if (x == NO_SYMBOL) begin
            dropping = 1'b1;
            r.finished = 1'b1;
            r.status = ST_BAD_CHAR;
            r.decoded_length = byte_total;
            expected_words.push_back(r);
            return;
        end
        if (byte_total == capacity) begin
            dropping = 1'b1;
            r.finished = 1'b1;
            r.status = ST_FULL;
            r.decoded_length = byte_total;
            expected_words.push_back(r);
            return;
        end
        case (group_pos)
            2'd0: begin
                carry_bits = {x[5:0], 2'b00};
                group_pos = 2'd1;
                return;
            end
            2'd1: begin
                full_byte = carry_bits | {6'd0, x[5:4]};
                next_bits = {x[3:0], 4'd0};
            end
            2'd2: begin
                full_byte = carry_bits | {4'd0, x[5:2]};
                next_bits = {x[1:0], 6'd0};
            end
            default: begin
                full_byte = carry_bits | x;
            end
        endcase
        byte_total = byte_total + 16'd1;
        r.data_byte = full_byte;
        r.byte_valid = 1'b1;
        r.decoded_length = byte_total;
        if (group_pos == 2'd3) begin
            carry_bits = 8'd0;
            group_pos = 2'd0;
        end else if (byte_total == capacity) begin
            dropping = 1'b1;
            r.finished = 1'b1;
            r.status = (next_bits == 8'd0) ? ST_OK : ST_TAIL;
        end else begin
            carry_bits = next_bits;
            group_pos = group_pos + 2'd1;
        end
        expected_words.push_back(r);
    endtask

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        out_word_t exp_word;
        if (!aresetn) begin
            capacity = CAPACITY_RESET;
            restart_message();
            expected_words.delete();
            mismatches = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word on m_data: %h", m_data);
                    mismatches++;
                end else begin
                    exp_word = expected_words.pop_front();
                    check_field("data_byte", 16'(exp_word.data_byte),
                                16'(m_data.data_byte));
                    check_field("byte_valid", 16'(exp_word.byte_valid),
                                16'(m_data.byte_valid));
                    check_field("finished", 16'(exp_word.finished),
                                16'(m_data.finished));
                    check_field("status", 16'(exp_word.status), 16'(m_data.status));
                    check_field("decoded_length", exp_word.decoded_length,
                                m_data.decoded_length);
                end
            end
            if (s_valid && s_ready) begin
                predict_word(s_data);
            end
            if (cfg_wr_en) begin
                capacity = cfg_wr_data;
            end
        end
        outstanding = expected_words.size();
    end

endmodule

>>> tb/tb_top.sv
// top of the base64url decoder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top
    import b64d_pkg::*;
();

    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 200000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    in_word_t    s_data;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_word_t   m_data;
    logic        no_gaps;
    int          mismatches;
    int          outstanding;
    int          cycles = 0;
    int          items_sent;

    base64url_stream_decoder_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    b64d_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(0, 99) >= 25);
    end

    function automatic logic [7:0] alphabet_char(input logic [5:0] v);
        if (v < 6'd26) begin
            return "A" + v;
        end else if (v < 6'd52) begin
            return "a" + (v - 6'd26);
        end else if (v < 6'd62) begin
            return "0" + (v - 6'd52);
        end else if (v == 6'd62) begin
            return "-";
        end
        return "_";
    endfunction

    task automatic send_word(input logic [7:0] ch, input logic eot);
        @(negedge aclk);
        while (!no_gaps && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data.text_char <= ch;
        s_data.end_of_text <= eot;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    task automatic send_end();
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_word(txt[i], 1'b0);
        end
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        settle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_message(input bit terminate);
        int len;
        logic [7:0] ch;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 24);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 4) begin
                ch = 8'($urandom_range(0, 255));
            end else begin
                ch = alphabet_char(6'($urandom_range(0, 63)));
            end
            send_word(ch, 1'b0);
        end
        if (terminate) begin
            send_end();
        end
    endtask

    initial begin
        logic [15:0] cap;
        int          phase_no;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 16'd0;
        s_valid = 1'b0;
        s_data = '0;
        no_gaps = 1'b0;
        items_sent = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // default capacity: alphabet range ends, leftover bits, dangling, empty, bad char
        send_text("AZaz09-_");
        send_end();
        send_text("QR");
        send_end();
        send_text("Q");
        send_end();
        send_end();
        send_word(8'hFF, 1'b0);
        send_text("x");
        send_end();

        // no room at all
        write_capacity(16'd0);
        send_text("A");
        send_end();

        // capacity filled mid-group with nonzero tail bits
        write_capacity(16'd1);
        send_text("QR");
        send_end();

        // capacity filled at the end of a group, then one more character
        write_capacity(16'd3);
        send_text("QUJDA");
        send_end();

        items_sent = 0;
        phase_no = 0;
        while (items_sent < RANDOM_ITEMS) begin
            settle();
            no_gaps <= (phase_no == 2);
            case ($urandom_range(0, 7))
                0: cap = 16'd0;
                1: cap = 16'd1;
                2: cap = 16'd2;
                3: cap = 16'd3;
                4: cap = 16'($urandom_range(4, 20));
                5: cap = 16'hFFFF;
                6: cap = 16'($urandom_range(0, 65535));
                default: cap = 16'($urandom_range(1, 10));
            endcase
            if (phase_no == 0) begin
                cap = 16'hFFFF;
            end
            write_capacity(cap);
            for (int m = 0; m < 6; m++) begin
                random_message((m != 5) || ($urandom_range(0, 1) == 1));
            end
            phase_no++;
        end
        send_end();

        settle();
        repeat (4) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
